### sv/epa_pkg.sv
// epa_pkg: shared types, register indexes and exp tables for the event potential accumulator
// no dependencies
`default_nettype none
package epa_pkg;

   localparam int DEF_SENSOR_WIDTH  = 512;
   localparam int DEF_SENSOR_HEIGHT = 256;

   localparam logic [2:0] CSR_DECAY_MODE   = 3'd0;
   localparam logic [2:0] CSR_DECAY_PARAM  = 3'd1;
   localparam logic [2:0] CSR_CONTRIBUTION = 3'd2;
   localparam logic [2:0] CSR_MIN_POT      = 3'd3;
   localparam logic [2:0] CSR_MAX_POT      = 3'd4;
   localparam logic [2:0] CSR_NEUTRAL_POT  = 3'd5;
   localparam logic [2:0] CSR_RECTIFY      = 3'd6;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_STEP = 2'd1;
   localparam logic [1:0] MODE_LIN  = 2'd2;
   localparam logic [1:0] MODE_EXP  = 2'd3;

   typedef struct packed {
      logic [1:0]         decay_mode;
      logic [31:0]        decay_param;
      logic [14:0]        event_contribution;
      logic signed [15:0] min_potential;
      logic signed [15:0] max_potential;
      logic signed [15:0] neutral_potential;
      logic               rectify_polarity;
   } cfg_type;

   typedef struct packed {
      logic        in_range;
      logic [8:0]  x;
      logic [7:0]  y;
      logic        polarity;
      logic [31:0] time_us;
   } evt_type;

   // exp(-n), Q1.16
   function automatic logic [16:0] exp_int(input logic [3:0] n);
      logic [16:0] v;
      unique case (n)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd24109;
         4'd2:  v = 17'd8869;
         4'd3:  v = 17'd3263;
         4'd4:  v = 17'd1200;
         4'd5:  v = 17'd442;
         4'd6:  v = 17'd162;
         4'd7:  v = 17'd60;
         4'd8:  v = 17'd22;
         4'd9:  v = 17'd8;
         4'd10: v = 17'd3;
         4'd11: v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // exp(-k/16), Q1.16
   function automatic logic [16:0] exp_six(input logic [3:0] k);
      logic [16:0] v;
      unique case (k)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd61565;
         4'd2:  v = 17'd57836;
         4'd3:  v = 17'd54331;
         4'd4:  v = 17'd51039;
         4'd5:  v = 17'd47947;
         4'd6:  v = 17'd45042;
         4'd7:  v = 17'd42313;
         4'd8:  v = 17'd39750;
         4'd9:  v = 17'd37341;
         4'd10: v = 17'd35079;
         4'd11: v = 17'd32954;
         4'd12: v = 17'd30957;
         4'd13: v = 17'd29081;
         4'd14: v = 17'd27319;
         default: v = 17'd25664;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### sv/epa_front.sv
// epa_front: accepts event words, checks the pixel against the sensor and forms its address
// depends on epa_pkg
`default_nettype none
module epa_front #(
   parameter int SENSOR_WIDTH  = epa_pkg::DEF_SENSOR_WIDTH,
   parameter int SENSOR_HEIGHT = epa_pkg::DEF_SENSOR_HEIGHT
) (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [8:0]           req_pixel_x,
   input  logic [7:0]           req_pixel_y,
   input  logic                 req_event_polarity,
   input  logic [31:0]          req_event_time,
   input  logic                 clearing,
   input  logic                 q_full,
   output logic                 push,
   output logic [$clog2(SENSOR_WIDTH*SENSOR_HEIGHT)-1:0] push_addr,
   output epa_pkg::evt_type     push_evt
);
   import epa_pkg::*;

   localparam int ADDR_W = $clog2(SENSOR_WIDTH*SENSOR_HEIGHT);

   assign req_ready = !clearing && !q_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_evt.in_range = (32'(req_pixel_x) < 32'(SENSOR_WIDTH)) &&
                          (32'(req_pixel_y) < 32'(SENSOR_HEIGHT));
      push_evt.x        = req_pixel_x;
      push_evt.y        = req_pixel_y;
      push_evt.polarity = req_event_polarity;
      push_evt.time_us  = req_event_time;
      push_addr = ADDR_W'(ADDR_W'(req_pixel_y) * ADDR_W'(SENSOR_WIDTH) + ADDR_W'(req_pixel_x));
   end

endmodule
`default_nettype wire

### sv/epa_queue.sv
// epa_queue: two-entry word queue between front and back
// depends on nothing
`default_nettype none
module epa_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic              full,
   output logic              empty
);
   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule
`default_nettype wire

### sv/epa_back.sv
// epa_back: pixel store, decay sequencer with divider and shared multiplier, result register
// depends on epa_pkg
`default_nettype none
module epa_back #(
   parameter int SENSOR_WIDTH  = epa_pkg::DEF_SENSOR_WIDTH,
   parameter int SENSOR_HEIGHT = epa_pkg::DEF_SENSOR_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  epa_pkg::cfg_type     cfg,
   input  logic                 q_empty,
   input  logic [$clog2(SENSOR_WIDTH*SENSOR_HEIGHT)-1:0] q_addr,
   input  epa_pkg::evt_type     q_evt,
   output logic                 q_pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [8:0]           rsp_out_x,
   output logic [7:0]           rsp_out_y,
   output logic signed [15:0]   rsp_new_potential
);
   import epa_pkg::*;

   localparam int PIXELS = SENSOR_WIDTH * SENSOR_HEIGHT;
   localparam int ADDR_W = $clog2(PIXELS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_LIN, ST_LIN_DONE, ST_EXP_CHK, ST_DIV,
      ST_RR, ST_R3, ST_EF, ST_FP, ST_FS, ST_S_DONE, ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [ADDR_W-1:0]  clear_cnt_ff;
   evt_type            cur_evt_ff;
   logic [ADDR_W-1:0]  cur_addr_ff;
   logic [47:0]        rd_word_ff;
   logic [47:0]        mem [PIXELS];
   logic [31:0]        dt_ff;
   logic [31:0]        old_time_ff;
   logic [16:0]        mag_ff;
   logic               neg_ff;
   logic signed [17:0] pdec_ff;
   logic [31:0]        rem_ff;
   logic [4:0]         div_cnt_ff;
   logic [19:0]        q_ff;
   logic [23:0]        rr_ff;
   logic [16:0]        poly_ff;
   logic [63:0]        prod_ff;
   logic               rsp_valid_ff;
   logic [8:0]         rsp_x_ff;
   logic [7:0]         rsp_y_ff;
   logic signed [15:0] rsp_pot_ff;

   logic [31:0]        mul_a;
   logic [31:0]        mul_b;
   logic               out_free;
   logic signed [16:0] diff;
   logic [35:0]        tau12;
   logic [32:0]        trial;
   logic               dbit;
   logic [47:0]        lin_amt;
   logic [16:0]        lin_s;
   logic [16:0]        exp_s;
   logic [1:0]         div6;
   logic [17:0]        poly_in;
   logic signed [18:0] contrib;
   logic signed [18:0] sum;
   logic signed [18:0] clamp_lo;
   logic signed [15:0] final_pot;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [47:0]        mem_wd;
   logic [31:0]        new_time;

   assign clearing  = (state_ff == ST_CLEAR);
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_new_potential = rsp_pot_ff;

   // shared multiplier operands
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         ST_LIN: begin
            mul_a = dt_ff;
            mul_b = cfg.decay_param;
         end
         ST_EXP_CHK: begin
            mul_a = (dt_ff == 32'd0) ? 32'd65536 : 32'd0;
            mul_b = 32'd65536;
         end
         ST_RR: begin
            mul_a = {20'd0, q_ff[11:0]};
            mul_b = {20'd0, q_ff[11:0]};
         end
         ST_R3: begin
            mul_a = {8'd0, prod_ff[23:0]};
            mul_b = {20'd0, q_ff[11:0]};
         end
         ST_EF: begin
            mul_a = {15'd0, exp_int(q_ff[19:16])};
            mul_b = {15'd0, exp_six(q_ff[15:12])};
         end
         ST_FP: begin
            mul_a = {15'd0, prod_ff[32:16]};
            mul_b = {15'd0, poly_ff};
         end
         ST_FS: begin
            mul_a = {15'd0, prod_ff[32:16]};
            mul_b = {15'd0, mag_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      diff    = 17'(signed'(rd_word_ff[15:0])) - 17'(cfg.neutral_potential);
      tau12   = {1'b0, cfg.decay_param, 3'd0} + {2'd0, cfg.decay_param, 2'd0};
      dbit    = (div_cnt_ff >= 5'd16) ? dt_ff[div_cnt_ff[1:0]] : 1'b0;
      trial   = {rem_ff, dbit};
      lin_amt = prod_ff[63:16];
      lin_s   = (lin_amt >= {31'd0, mag_ff}) ? 17'd0 : (mag_ff - lin_amt[16:0]);
      exp_s   = prod_ff[32:16];
      div6    = (prod_ff[35:32] >= 4'd12) ? 2'd2 : ((prod_ff[35:32] >= 4'd6) ? 2'd1 : 2'd0);
      poly_in = 18'd65536 - {6'd0, q_ff[11:0]} + {11'd0, rr_ff[23:17]} - {16'd0, div6};
      contrib = (!cfg.rectify_polarity && !cur_evt_ff.polarity) ?
                -19'(cfg.event_contribution) : 19'(cfg.event_contribution);
      sum      = 19'(pdec_ff) + contrib;
      clamp_lo = (sum < 19'(cfg.min_potential)) ? 19'(cfg.min_potential) : sum;
      final_pot = (clamp_lo > 19'(cfg.max_potential)) ? cfg.max_potential : clamp_lo[15:0];
      new_time = (cfg.decay_mode == MODE_LIN || cfg.decay_mode == MODE_EXP) ?
                 cur_evt_ff.time_us : old_time_ff;
      mem_we = clearing || (state_ff == ST_FINISH && out_free && cur_evt_ff.in_range);
      mem_wa = clearing ? clear_cnt_ff : cur_addr_ff;
      mem_wd = clearing ? 48'd0 : {new_time, final_pot};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_word_ff <= mem[q_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               if (clear_cnt_ff == LAST_ADDR) state_ff <= ST_IDLE;
               else clear_cnt_ff <= clear_cnt_ff + 1'b1;
            end
            ST_IDLE: begin
               if (!q_empty) begin
                  cur_evt_ff  <= q_evt;
                  cur_addr_ff <= q_addr;
                  pdec_ff     <= 18'sd0;
                  state_ff    <= q_evt.in_range ? ST_LOAD : ST_FINISH;
               end
            end
            ST_LOAD: begin
               dt_ff       <= cur_evt_ff.time_us - rd_word_ff[47:16];
               old_time_ff <= rd_word_ff[47:16];
               neg_ff      <= diff[16];
               mag_ff      <= diff[16] ? 17'(-diff) : 17'(diff);
               pdec_ff     <= 18'(signed'(rd_word_ff[15:0]));
               unique case (cfg.decay_mode)
                  MODE_LIN: state_ff <= ST_LIN;
                  MODE_EXP: state_ff <= ST_EXP_CHK;
                  default:  state_ff <= ST_FINISH;
               endcase
            end
            ST_LIN: state_ff <= ST_LIN_DONE;
            ST_LIN_DONE: begin
               pdec_ff  <= neg_ff ? 18'(cfg.neutral_potential) - 18'(lin_s) :
                                    18'(cfg.neutral_potential) + 18'(lin_s);
               state_ff <= ST_FINISH;
            end
            ST_EXP_CHK: begin
               if (dt_ff == 32'd0 || cfg.decay_param == 32'd0 || {4'd0, dt_ff} >= tau12) begin
                  state_ff <= ST_FS;
               end else begin
                  rem_ff     <= {4'd0, dt_ff[31:4]};
                  div_cnt_ff <= 5'd19;
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (trial >= {1'b0, cfg.decay_param}) begin
                  rem_ff <= 32'(trial - {1'b0, cfg.decay_param});
                  q_ff   <= {q_ff[18:0], 1'b1};
               end else begin
                  rem_ff <= trial[31:0];
                  q_ff   <= {q_ff[18:0], 1'b0};
               end
               if (div_cnt_ff == 5'd0) state_ff <= ST_RR;
               else div_cnt_ff <= div_cnt_ff - 1'b1;
            end
            ST_RR: state_ff <= ST_R3;
            ST_R3: begin
               rr_ff    <= prod_ff[23:0];
               state_ff <= ST_EF;
            end
            ST_EF: begin
               poly_ff  <= poly_in[16:0];
               state_ff <= ST_FP;
            end
            ST_FP: state_ff <= ST_FS;
            ST_FS: state_ff <= ST_S_DONE;
            ST_S_DONE: begin
               pdec_ff  <= neg_ff ? 18'(cfg.neutral_potential) - 18'(exp_s) :
                                    18'(cfg.neutral_potential) + 18'(exp_s);
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= cur_evt_ff.x;
                  rsp_y_ff     <= cur_evt_ff.y;
                  rsp_pot_ff   <= cur_evt_ff.in_range ? final_pot : 16'sd0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_no_rsp_while_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid_ff)
      else $error("result shown during clearing pass");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !out_free) |=> state_ff == ST_FINISH)
      else $error("result lost while receiver stalled");

   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RR) |-> (q_ff[19:16] < 4'd12))
      else $error("quotient out of table range");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_valid_ff || state_ff == ST_IDLE) && !clearing)
      else $error("queue popped while clearing");

endmodule
`default_nettype wire

### sv/event_potential_accumulator_unit.sv
// event_potential_accumulator_unit: top level, control registers and front/queue/back hookup
// depends on epa_pkg, epa_front, epa_queue, epa_back
//
// req_ carries one event word (pixel, polarity, time); rsp_ returns one word per event
// with the pixel and its new potential, in order, valid/ready on both sides.
// csr_ is a write-only register port; the user must write it only while the unit is idle,
// as the unit does not check it. after reset the pixel store is swept to zero, one
// pixel a cycle, over all SENSOR_WIDTH*SENSOR_HEIGHT pixels (131072 by default); req_ready
// stays low meanwhile. with the back idle, an event in none or step mode goes from the
// store read straight to the result register; linear mode adds a multiplier pass, and
// exponential mode the 20-step divider where needed and the shared multiplier passes in
// the back sequencer; pixels outside the sensor skip the store read.
// one event is worked at a time; a two-word queue lets the front keep taking words
// while the back works, and a result register holds the last result while the
// receiver stalls, the back waiting only when that register is still full.
`default_nettype none
module event_potential_accumulator_unit #(
   parameter int SENSOR_WIDTH  = epa_pkg::DEF_SENSOR_WIDTH,
   parameter int SENSOR_HEIGHT = epa_pkg::DEF_SENSOR_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [8:0]         req_pixel_x,
   input  logic [7:0]         req_pixel_y,
   input  logic               req_event_polarity,
   input  logic [31:0]        req_event_time,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [8:0]         rsp_out_x,
   output logic [7:0]         rsp_out_y,
   output logic signed [15:0] rsp_new_potential,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);
   import epa_pkg::*;

   localparam int ADDR_W = $clog2(SENSOR_WIDTH*SENSOR_HEIGHT);
   localparam int QW     = ADDR_W + $bits(evt_type);

   cfg_type           cfg_ff;
   logic              clearing;
   logic              q_full;
   logic              q_empty;
   logic              push;
   logic              pop;
   logic [ADDR_W-1:0] push_addr;
   evt_type           push_evt;
   logic [QW-1:0]     head;
   logic [ADDR_W-1:0] head_addr;
   evt_type           head_evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_mode         <= MODE_EXP;
         cfg_ff.decay_param        <= 32'd1000000;
         cfg_ff.event_contribution <= 15'd38;
         cfg_ff.min_potential      <= 16'sd0;
         cfg_ff.max_potential      <= 16'sd256;
         cfg_ff.neutral_potential  <= 16'sd0;
         cfg_ff.rectify_polarity   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DECAY_MODE:   cfg_ff.decay_mode         <= csr_write_data[1:0];
            CSR_DECAY_PARAM:  cfg_ff.decay_param        <= csr_write_data;
            CSR_CONTRIBUTION: cfg_ff.event_contribution <= csr_write_data[14:0];
            CSR_MIN_POT:      cfg_ff.min_potential      <= csr_write_data[15:0];
            CSR_MAX_POT:      cfg_ff.max_potential      <= csr_write_data[15:0];
            CSR_NEUTRAL_POT:  cfg_ff.neutral_potential  <= csr_write_data[15:0];
            CSR_RECTIFY:      cfg_ff.rectify_polarity   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   epa_front #(
      .SENSOR_WIDTH  (SENSOR_WIDTH),
      .SENSOR_HEIGHT (SENSOR_HEIGHT)
   ) u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_x        (req_pixel_x),
      .req_pixel_y        (req_pixel_y),
      .req_event_polarity (req_event_polarity),
      .req_event_time     (req_event_time),
      .clearing           (clearing),
      .q_full             (q_full),
      .push               (push),
      .push_addr          (push_addr),
      .push_evt           (push_evt)
   );

   epa_queue #(
      .DATA_W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_addr, push_evt}),
      .pop       (pop),
      .head_data (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign head_addr = head[QW-1 -: ADDR_W];
   assign head_evt  = head[$bits(evt_type)-1:0];

   epa_back #(
      .SENSOR_WIDTH  (SENSOR_WIDTH),
      .SENSOR_HEIGHT (SENSOR_HEIGHT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_empty           (q_empty),
      .q_addr            (head_addr),
      .q_evt             (head_evt),
      .q_pop             (pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_new_potential (rsp_new_potential)
   );

endmodule
`default_nettype wire
